### design/irss_pkg.sv
// irss_pkg: shared types and constants for the interference rhythm step sequencer
// used by irss_rem_unit and interference_rhythm_step_sequencer; no dependencies
package irss_pkg;

    localparam int GEN_W      = 4;
    localparam int JUMP_W     = 8;
    localparam int LANE_BITS  = 9;
    localparam int LANE_IDX_W = 4;
    localparam int STEP_OUT_W = 7;
    localparam int DIV_W      = 8;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic CFG_GEN_A = 1'b0;
    localparam logic CFG_GEN_B = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } rem_rsp_t;

endpackage

### design/irss_rem_unit.sv
// irss_rem_unit: shared restoring remainder unit, one quotient bit per cycle
// depends on irss_pkg for the request and response structs

module irss_rem_unit
    import irss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // compare and subtract one bit position
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### design/interference_rhythm_step_sequencer.sv
// interference_rhythm_step_sequencer: step counter and rhythm pattern tests per sample
// depends on irss_pkg and irss_rem_unit
// flow: a sample passes through prep, step advance, first generator test and the lane scan;
// a reset pulse without a jump skips the advance remainder; each remainder runs in the shared
// unit, and the scan waits on it only for a lane that needs one
// one sample at a time; reset: step and last jump clear, generators 1

module interference_rhythm_step_sequencer
    import irss_pkg::*;
#(
    parameter int MAX_GENERATOR = 9,
    parameter int SAMPLE_BITS   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [0:0]             cfg_index,
    input  logic [GEN_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // click_sample, reset_pulse, jump_step, zero pad
    input  logic [((SAMPLE_BITS + 1 + JUMP_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // resultant_sample, first_gen_sample, lane_mask, click_through,
    // cycle_start, step_number, zero pad
    output logic [((3 * SAMPLE_BITS + LANE_BITS + 1 + STEP_OUT_W + 7) / 8) * 8 - 1:0]
                                   m_axis_tdata
);

    localparam int OUT_W  = ((3 * SAMPLE_BITS + LANE_BITS + 1 + STEP_OUT_W + 7) / 8) * 8;
    localparam int STEP_W = $clog2(MAX_GENERATOR * MAX_GENERATOR);

    localparam logic [GEN_W-1:0] MAX_GEN_V = GEN_W'(MAX_GENERATOR);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_ADV   = 4'd2;
    localparam logic [3:0] ST_MWAIT = 4'd3;
    localparam logic [3:0] ST_FIRST = 4'd4;
    localparam logic [3:0] ST_FWAIT = 4'd5;
    localparam logic [3:0] ST_LANE  = 4'd6;
    localparam logic [3:0] ST_LWAIT = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [GEN_W-1:0]       gen_a_reg, gen_a_next;
    logic [GEN_W-1:0]       gen_b_reg, gen_b_next;
    logic [GEN_W-1:0]       a_reg, a_next;
    logic [GEN_W-1:0]       b_reg, b_next;
    logic [DIV_W-1:0]       steps_reg, steps_next;
    logic [DIV_W-1:0]       ab_reg, ab_next;
    logic [SAMPLE_BITS-1:0] click_reg, click_next;
    logic                   rstp_reg, rstp_next;
    logic [JUMP_W-1:0]      jump_reg, jump_next;
    logic [JUMP_W-1:0]      last_jump_reg, last_jump_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   first_hit_reg, first_hit_next;
    logic [LANE_BITS-1:0]   lanes_reg, lanes_next;
    logic                   hi_hit_reg, hi_hit_next;
    logic [LANE_IDX_W-1:0]  j_reg, j_next;
    logic [DIV_W-1:0]       d_reg, d_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    rem_req_t               rem_req;
    rem_rsp_t               rem_rsp;

    logic [GEN_W-1:0]       a_clamp;
    logic [GEN_W-1:0]       b_clamp;
    logic                   pos;
    logic                   jump_load;
    logic                   lane_ok;
    logic                   candidate;
    logic                   d_ge_a;
    logic [DIV_W-1:0]       step_ext;
    logic                   any_hit;
    logic                   cycle_start;
    logic [SAMPLE_BITS-1:0] res_sample;
    logic [SAMPLE_BITS-1:0] first_sample;

    irss_rem_unit u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign a_clamp = (gen_a_reg == '0) ? GEN_W'(1) :
                     (gen_a_reg > MAX_GEN_V) ? MAX_GEN_V : gen_a_reg;
    assign b_clamp = (gen_b_reg == '0) ? GEN_W'(1) :
                     (gen_b_reg > a_clamp) ? a_clamp : gen_b_reg;

    assign pos       = !click_reg[SAMPLE_BITS-1] && (click_reg != '0);
    assign jump_load = (jump_reg != last_jump_reg) && (jump_reg != '0);
    assign lane_ok   = ((5'(j_reg) + 5'(b_reg)) <= 5'(a_reg));
    assign candidate = lane_ok && (d_reg < ab_reg);
    assign d_ge_a    = d_reg >= DIV_W'(a_reg);
    assign step_ext  = DIV_W'(step_reg);

    // lanes above the mask still count toward the resultant
    assign any_hit      = first_hit_reg || (lanes_reg != '0) || hi_hit_reg;
    assign cycle_start  = (step_reg == '0) && (click_reg != '0);
    assign res_sample   = any_hit ? click_reg : '0;
    assign first_sample = first_hit_reg ? click_reg : '0;

    always_comb
    begin
        state_next       = state_reg;
        gen_a_next       = gen_a_reg;
        gen_b_next       = gen_b_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        steps_next       = steps_reg;
        ab_next          = ab_reg;
        click_next       = click_reg;
        rstp_next        = rstp_reg;
        jump_next        = jump_reg;
        last_jump_next   = last_jump_reg;
        step_next        = step_reg;
        first_hit_next   = first_hit_reg;
        lanes_next       = lanes_reg;
        hi_hit_next      = hi_hit_reg;
        j_next           = j_reg;
        d_next           = d_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = step_ext;
        rem_req.divisor  = steps_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GEN_A: gen_a_next = cfg_data;
                CFG_GEN_B: gen_b_next = cfg_data;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    click_next = s_axis_tdata[SAMPLE_BITS-1:0];
                    rstp_next  = s_axis_tdata[SAMPLE_BITS];
                    jump_next  = s_axis_tdata[SAMPLE_BITS+JUMP_W:SAMPLE_BITS+1];
                    a_next     = a_clamp;
                    b_next     = b_clamp;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                steps_next = DIV_W'(a_reg) * DIV_W'(a_reg);
                ab_next    = DIV_W'(a_reg) * DIV_W'(b_reg);
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                last_jump_next = jump_reg;
                if (jump_load)
                begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = DIV_W'(jump_reg - JUMP_W'(1));
                    state_next       = ST_MWAIT;
                end
                else if (rstp_reg)
                begin
                    step_next  = '0;
                    state_next = ST_FIRST;
                end
                else
                begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = step_ext + DIV_W'(pos);
                    state_next       = ST_MWAIT;
                end
            end
            ST_MWAIT:
            begin
                if (rem_rsp.done)
                begin
                    step_next  = rem_rsp.rem[STEP_W-1:0];
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                rem_req.start   = 1'b1;
                rem_req.divisor = DIV_W'(a_reg);
                state_next      = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                if (rem_rsp.done)
                begin
                    first_hit_next = (rem_rsp.rem == '0);
                    lanes_next     = '0;
                    hi_hit_next    = 1'b0;
                    j_next         = '0;
                    d_next         = step_ext;
                    state_next     = ST_LANE;
                end
            end
            ST_LANE:
            begin
                if (!lane_ok)
                begin
                    state_next = ST_DONE;
                end
                else if (candidate)
                begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = d_reg;
                    rem_req.divisor  = DIV_W'(b_reg);
                    state_next       = ST_LWAIT;
                end
                else
                begin
                    // lane misses; move base down by a
                    j_next = j_reg + 1'b1;
                    if (d_ge_a)
                    begin
                        d_next = d_reg - DIV_W'(a_reg);
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LWAIT:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.rem == '0)
                    begin
                        if (j_reg < LANE_IDX_W'(LANE_BITS))
                        begin
                            lanes_next[j_reg] = 1'b1;
                        end
                        else
                        begin
                            hi_hit_next = 1'b1;
                        end
                    end
                    j_next = j_reg + 1'b1;
                    if (d_ge_a)
                    begin
                        d_next     = d_reg - DIV_W'(a_reg);
                        state_next = ST_LANE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({step_ext[STEP_OUT_W-1:0], cycle_start,
                                             click_reg, lanes_reg, first_sample,
                                             res_sample});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_a_reg     <= GEN_W'(1);
            gen_b_reg     <= GEN_W'(1);
            last_jump_reg <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_a_reg     <= gen_a_next;
            gen_b_reg     <= gen_b_next;
            last_jump_reg <= last_jump_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        steps_reg     <= steps_next;
        ab_reg        <= ab_next;
        click_reg     <= click_next;
        rstp_reg      <= rstp_next;
        jump_reg      <= jump_next;
        first_hit_reg <= first_hit_next;
        lanes_reg     <= lanes_next;
        hi_hit_reg    <= hi_hit_next;
        j_reg         <= j_next;
        d_reg         <= d_next;
        out_data_reg  <= out_data_next;
    end

endmodule
